// ===== rtl/psd_pkg.sv =====
// Package for the preorder span tree decoder.
// Holds the sizing constants, status codes and the shared types.
// No dependencies.
package psd_pkg;

	localparam int MAX_ENTRIES = 4096;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int SPAN_W      = IDX_W + 1;
	localparam int DEPTH_W     = IDX_W + 1;
	localparam int LEN_W       = 13;
	localparam int CNT_W       = 12;
	localparam int STAT_W      = 2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_ROOT  = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVF   = 2'd2;
	localparam logic [STAT_W-1:0] ST_CROSS = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [SPAN_W-1:0] span;
	} stack_entry_t;

	localparam int ENTRY_W = $bits(stack_entry_t);

	typedef struct packed {
		logic gt;
		logic eq;
	} cmp_res_t;

endpackage

// ===== rtl/preorder_span_tree_decoder.sv =====
// Top level of the preorder span tree decoder: sequencer, stack control and ports.
// Depends on psd_pkg, psd_ram and psd_cmp.
//
// Channel   Direction  Handshake            Payload
// config    in         cfg_we               entry_count
// request   in         in_valid/in_ready    descendant_count
// result    out        out_valid/out_ready  edge_valid, parent_index, child_index,
//                                           status, list_end
//
// Each request passes through the root, pop, overflow, crossing and output steps; every
// pop that leaves the stack non-empty adds a wait step for the stack read, while a pop
// that empties it goes straight on. The steps are set by the single comparator and the
// one-read-per-pop stack memory. Pops never outnumber pushes.
// Reset clears the position, stack depth, error status and sets the length to 1.
// A stalled result holds in its register; the next request is taken meanwhile and
// waits in its final step until the result register is free.
module preorder_span_tree_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [psd_pkg::LEN_W-1:0]   entry_count,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [psd_pkg::CNT_W-1:0]   descendant_count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        edge_valid,
	output logic [psd_pkg::IDX_W-1:0]   parent_index,
	output logic [psd_pkg::IDX_W-1:0]   child_index,
	output logic [psd_pkg::STAT_W-1:0]  status,
	output logic                        list_end
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROOT  = 3'd1;
	localparam logic [2:0] S_POP   = 3'd2;
	localparam logic [2:0] S_POPW  = 3'd3;
	localparam logic [2:0] S_OVF   = 3'd4;
	localparam logic [2:0] S_CROSS = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	localparam int IDX_W   = psd_pkg::IDX_W;
	localparam int SPAN_W  = psd_pkg::SPAN_W;
	localparam int DEPTH_W = psd_pkg::DEPTH_W;
	localparam int LEN_W   = psd_pkg::LEN_W;

	logic [2:0]                 state_q;
	logic [LEN_W-1:0]           len_cfg_q;
	logic [IDX_W-1:0]           pos_q;
	logic [DEPTH_W-1:0]         depth_q;
	logic [psd_pkg::STAT_W-1:0] err_q;
	logic [psd_pkg::CNT_W-1:0]  count_q;
	logic [SPAN_W-1:0]          span_q;
	logic [IDX_W-1:0]           last_q;
	logic                       ok_q;
	logic                       edge_q;
	logic [IDX_W-1:0]           parent_q;
	psd_pkg::stack_entry_t      top_q;

	logic                       out_valid_q;
	logic                       edge_valid_q;
	logic [IDX_W-1:0]           parent_index_q;
	logic [IDX_W-1:0]           child_index_q;
	logic [psd_pkg::STAT_W-1:0] status_q;
	logic                       list_end_q;

	logic [LEN_W-1:0]           eff_len;
	logic [LEN_W-1:0]           eff_last;
	logic [SPAN_W-1:0]          cmp_a;
	logic [SPAN_W-1:0]          cmp_b;
	psd_pkg::cmp_res_t          cmp_res;
	logic [DEPTH_W-1:0]         depth_m2;
	logic                       ram_we;
	psd_pkg::stack_entry_t      push_entry;
	logic [psd_pkg::ENTRY_W-1:0] ram_rdata;
	logic                       out_free;
	logic                       at_end;

	always_comb begin
		eff_len = len_cfg_q;
		if (len_cfg_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (len_cfg_q > LEN_W'(psd_pkg::MAX_ENTRIES)) begin
			eff_len = LEN_W'(psd_pkg::MAX_ENTRIES);
		end
		eff_last = eff_len - LEN_W'(1);
	end

	always_comb begin
		cmp_a = {1'b0, pos_q};
		cmp_b = top_q.span;
		unique case (state_q)
			S_ROOT: begin
				cmp_a = SPAN_W'(count_q);
				cmp_b = {1'b0, last_q};
			end
			S_OVF: begin
				cmp_a = span_q;
				cmp_b = {1'b0, last_q};
			end
			S_CROSS: begin
				cmp_a = span_q;
				cmp_b = top_q.span;
			end
			default: begin
				cmp_a = {1'b0, pos_q};
				cmp_b = top_q.span;
			end
		endcase
	end

	psd_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	assign depth_m2       = depth_q - DEPTH_W'(2);
	assign out_free       = !out_valid_q || out_ready;
	assign at_end         = (pos_q >= last_q);
	assign push_entry.idx = pos_q;
	assign push_entry.span = span_q;
	assign ram_we         = (state_q == S_OUT) && out_free &&
	                        (depth_q < DEPTH_W'(psd_pkg::MAX_ENTRIES));

	psd_ram #(
		.WIDTH (psd_pkg::ENTRY_W),
		.DEPTH (psd_pkg::MAX_ENTRIES)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (depth_q[IDX_W-1:0]),
		.wdata (push_entry),
		.raddr (depth_m2[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_cfg_q   <= LEN_W'(1);
			pos_q       <= '0;
			depth_q     <= '0;
			err_q       <= psd_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_cfg_q <= entry_count;
			end
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (pos_q == '0 && !cmp_res.eq && err_q == psd_pkg::ST_OK) begin
						err_q <= psd_pkg::ST_ROOT;
					end
					state_q <= S_POP;
				end
				S_POP: begin
					if (depth_q != '0 && cmp_res.gt) begin
						depth_q <= depth_q - DEPTH_W'(1);
						state_q <= (depth_q > DEPTH_W'(1)) ? S_POPW : S_OVF;
					end else begin
						state_q <= S_OVF;
					end
				end
				S_POPW: begin
					state_q <= S_POP;
				end
				S_OVF: begin
					if (cmp_res.gt && err_q == psd_pkg::ST_OK) begin
						err_q <= psd_pkg::ST_OVF;
					end
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					if (pos_q != '0 && ok_q && (depth_q == '0 || cmp_res.gt) &&
					    err_q == psd_pkg::ST_OK) begin
						err_q <= psd_pkg::ST_CROSS;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (at_end) begin
							pos_q   <= '0;
							depth_q <= '0;
							err_q   <= psd_pkg::ST_OK;
						end else begin
							pos_q <= pos_q + IDX_W'(1);
							if (ram_we) begin
								depth_q <= depth_q + DEPTH_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				count_q <= descendant_count;
				span_q  <= {1'b0, pos_q} + SPAN_W'(descendant_count);
				last_q  <= eff_last[IDX_W-1:0];
			end
			S_POPW: begin
				top_q <= ram_rdata;
			end
			S_OVF: begin
				ok_q <= !cmp_res.gt;
			end
			S_CROSS: begin
				if (pos_q != '0 && ok_q && depth_q != '0 && !cmp_res.gt) begin
					edge_q   <= 1'b1;
					parent_q <= top_q.idx;
				end else begin
					edge_q   <= 1'b0;
					parent_q <= '0;
				end
			end
			S_OUT: begin
				if (out_free) begin
					edge_valid_q   <= edge_q;
					parent_index_q <= parent_q;
					child_index_q  <= pos_q;
					status_q       <= err_q;
					list_end_q     <= at_end;
					if (ram_we) begin
						top_q <= push_entry;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign edge_valid   = edge_valid_q;
	assign parent_index = parent_index_q;
	assign child_index  = child_index_q;
	assign status       = status_q;
	assign list_end     = list_end_q;

endmodule

// ===== rtl/psd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the ancestor stack. No dependencies.
module psd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/psd_cmp.sv =====
// Shared magnitude comparator used by the root, pop, overflow and crossing steps of the sequencer.
// Depends on psd_pkg.
module psd_cmp (
	input  logic [psd_pkg::SPAN_W-1:0] a,
	input  logic [psd_pkg::SPAN_W-1:0] b,
	output psd_pkg::cmp_res_t          res
);

	logic [psd_pkg::SPAN_W:0] diff;

	// A borrow out of b - a means a is greater than b.
	assign diff   = {1'b0, b} - {1'b0, a};
	assign res.gt = diff[psd_pkg::SPAN_W];
	assign res.eq = (a == b);

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for preorder_span_tree_decoder: drives preorder lists of
// descendant counts and checks every edge result against a built-in predictor.
// Depends on psd_pkg and the preorder_span_tree_decoder RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 20000;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [psd_pkg::LEN_W-1:0]    entry_count;
	logic                         in_valid;
	logic                         in_ready;
	logic [psd_pkg::CNT_W-1:0]    descendant_count;
	logic                         out_valid;
	logic                         out_ready;
	logic                         edge_valid;
	logic [psd_pkg::IDX_W-1:0]    parent_index;
	logic [psd_pkg::IDX_W-1:0]    child_index;
	logic [psd_pkg::STAT_W-1:0]   status;
	logic                         list_end;

	int src_idle_pct;
	int sink_idle_pct;
	int calm_left;
	int quiet_cycles;
	int node_counts[$];

	class edge_scoreboard;
		typedef struct packed {
			logic                       edge_v;
			logic [psd_pkg::IDX_W-1:0]  parent;
			logic [psd_pkg::IDX_W-1:0]  child;
			logic [psd_pkg::STAT_W-1:0] stat;
			logic                       last;
		} edge_t;

		edge_t                      expected_edges[$];
		int                         stack_idx[psd_pkg::MAX_ENTRIES];
		int                         stack_end[psd_pkg::MAX_ENTRIES];
		int                         depth;
		int                         position;
		logic [psd_pkg::STAT_W-1:0] err;
		logic [psd_pkg::LEN_W-1:0]  length_reg;
		int                         failures;

		function new();
			depth      = 0;
			position   = 0;
			err        = psd_pkg::ST_OK;
			length_reg = psd_pkg::LEN_W'(1);
			failures   = 0;
		endfunction

		function void latch_error(input logic [psd_pkg::STAT_W-1:0] code);
			if (err == psd_pkg::ST_OK) begin
				err = code;
			end
		endfunction

		function void note_node(input logic [psd_pkg::CNT_W-1:0] count_in);
			int    len;
			int    last;
			int    pos;
			int    cnt;
			bit    node_ok;
			edge_t e;
			len = (length_reg == 0) ? 1 :
			      ((length_reg > psd_pkg::MAX_ENTRIES) ? psd_pkg::MAX_ENTRIES :
			       int'(length_reg));
			last = len - 1;
			pos = position;
			cnt = int'(count_in);
			node_ok = 1'b1;
			e = '0;
			if (pos == 0 && cnt != last) begin
				latch_error(psd_pkg::ST_ROOT);
			end
			while (depth > 0 && pos > stack_end[depth-1]) begin
				depth--;
			end
			if (pos > last || cnt > last - pos) begin
				latch_error(psd_pkg::ST_OVF);
				node_ok = 1'b0;
			end
			if (pos != 0 && node_ok) begin
				if (depth == 0 || pos + cnt > stack_end[depth-1]) begin
					latch_error(psd_pkg::ST_CROSS);
				end else begin
					e.edge_v = 1'b1;
					e.parent = psd_pkg::IDX_W'(stack_idx[depth-1]);
				end
			end
			if (depth < psd_pkg::MAX_ENTRIES) begin
				stack_idx[depth] = pos;
				stack_end[depth] = pos + cnt;
				depth++;
			end
			e.child = psd_pkg::IDX_W'(pos);
			e.stat  = err;
			e.last  = (pos + 1 >= len);
			expected_edges.insert(expected_edges.size(), e);
			if (e.last) begin
				position = 0;
				depth    = 0;
				err      = psd_pkg::ST_OK;
			end else begin
				position = pos + 1;
			end
		endfunction

		function void compare_field(input string name, input int exp_v, input int act_v);
			if (exp_v != act_v) begin
				failures++;
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_edge(input logic ev, input logic [psd_pkg::IDX_W-1:0] par,
		                         input logic [psd_pkg::IDX_W-1:0] chi,
		                         input logic [psd_pkg::STAT_W-1:0] st, input logic le);
			edge_t e;
			if (expected_edges.size() == 0) begin
				failures++;
				$display("%0t: unexpected result: expected none, actual child %0d status %0d",
				         $time, chi, st);
				return;
			end
			e = expected_edges.pop_front();
			compare_field("edge_valid", e.edge_v, ev);
			compare_field("parent_index", e.parent, par);
			compare_field("child_index", e.child, chi);
			compare_field("status", e.stat, st);
			compare_field("list_end", e.last, le);
		endfunction
	endclass

	edge_scoreboard sb;

	preorder_span_tree_decoder dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.entry_count      (entry_count),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.descendant_count (descendant_count),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.edge_valid       (edge_valid),
		.parent_index     (parent_index),
		.child_index      (child_index),
		.status           (status),
		.list_end         (list_end)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Occasional windows in which neither side idles.
	always @(negedge clk) begin
		if (calm_left != 0) begin
			calm_left <= calm_left - 1;
		end else if ($urandom_range(0, 199) == 0) begin
			calm_left <= $urandom_range(20, 80);
		end
	end

	always @(negedge clk) begin
		out_ready <= !(calm_left == 0 && $urandom_range(0, 99) < sink_idle_pct);
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_edge(edge_valid, parent_index, child_index, status, list_end);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic bit sender_pause();
		return calm_left == 0 && $urandom_range(0, 99) < src_idle_pct;
	endfunction

	task automatic send_nodes();
		while (node_counts.size() != 0) begin
			@(negedge clk);
			if (sender_pause()) begin
				in_valid <= 1'b0;
			end else begin
				in_valid         <= 1'b1;
				descendant_count <= psd_pkg::CNT_W'(node_counts[0]);
				do @(posedge clk); while (!in_ready);
				sb.note_node(psd_pkg::CNT_W'(node_counts.pop_front()));
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sb.expected_edges.size() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
	endtask

	task automatic write_length(input logic [psd_pkg::LEN_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_we      <= 1'b1;
		entry_count <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.length_reg = value;
	endtask

	// Random well-formed preorder tree: each node hangs off the current right-hand path.
	function automatic void queue_tree(input int n, input int keep);
		int par[];
		int size[];
		int path[$];
		int pops;
		par  = new[n];
		size = new[n];
		path.insert(path.size(), 0);
		size[0] = 1;
		for (int i = 1; i < n; i++) begin
			pops = ($urandom_range(0, 1) == 0) ? $urandom_range(0, path.size() - 1) : 0;
			repeat (pops) path.delete(path.size() - 1);
			par[i]  = path[path.size() - 1];
			size[i] = 1;
			path.insert(path.size(), i);
		end
		for (int i = n - 1; i > 0; i--) begin
			size[par[i]] += size[i];
		end
		for (int i = 0; i < keep; i++) begin
			node_counts.insert(node_counts.size(), size[i] - 1);
		end
	endfunction

	function automatic void queue_list(input int n);
		int base;
		int pick;
		base = node_counts.size();
		pick = $urandom_range(0, 99);
		if (pick < 90) begin
			queue_tree(n, n);
			if (pick >= 75) begin
				node_counts[base + $urandom_range(0, n - 1)] =
					($urandom_range(0, 1) != 0) ? $urandom_range(0, n) : $urandom_range(0, 4095);
			end
		end else begin
			repeat (n) begin
				node_counts.insert(node_counts.size(),
				                   ($urandom_range(0, 1) != 0) ? $urandom_range(0, n) :
				                   $urandom_range(0, 4095));
			end
		end
	endfunction

	task automatic run_random(input int target);
		int sent;
		int n;
		int pick;
		bit zero_len;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(0, 99);
			zero_len = 1'b0;
			if (pick < 60) begin
				n = $urandom_range(2, 8);
			end else if (pick < 85) begin
				n = $urandom_range(9, 40);
			end else if (pick < 95) begin
				n = $urandom_range(41, 150);
			end else begin
				n = 1;
				zero_len = ($urandom_range(0, 1) != 0);
			end
			write_length(zero_len ? psd_pkg::LEN_W'(0) : psd_pkg::LEN_W'(n));
			repeat ($urandom_range(1, 6)) queue_list(n);
			// A list cut short leaves the block mid-list for the next length change.
			if (n > 2 && $urandom_range(0, 9) == 0) begin
				queue_tree(n, $urandom_range(1, n - 1));
			end
			sent += node_counts.size();
			send_nodes();
		end
	endtask

	initial begin
		sb               = new();
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		entry_count      = psd_pkg::LEN_W'(1);
		in_valid         = 1'b0;
		descendant_count = '0;
		out_ready        = 1'b0;
		calm_left        = 0;
		quiet_cycles     = 0;
		src_idle_pct     = 36;
		sink_idle_pct    = 86;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		write_length(psd_pkg::LEN_W'(0));
		node_counts = '{0, 4095};
		send_nodes();
		write_length(psd_pkg::LEN_W'(1));
		node_counts = '{5};
		send_nodes();
		write_length(psd_pkg::LEN_W'(4));
		node_counts = '{3, 1, 0, 0, 3, 1, 1, 0, 3, 3, 0, 0};
		send_nodes();
		write_length(psd_pkg::LEN_W'(3));
		node_counts = '{0, 0, 0};
		send_nodes();
		write_length(psd_pkg::LEN_W'(4096));
		node_counts = '{4095, 4094, 0};
		send_nodes();
		write_length(psd_pkg::LEN_W'(8191));
		write_length(psd_pkg::LEN_W'(2));
		node_counts = '{4095};
		send_nodes();

		run_random(500);
		src_idle_pct  = 86;
		sink_idle_pct = 36;
		run_random(500);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		run_random(500);

		wait_idle();
		if (sb.failures == 0 && sb.expected_edges.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
